>>> hw/rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// Gap-buffer text store: shared definitions
// Field widths, operation and status codes, and the command and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gbts_pkg;

    localparam int DEPTH_DEFAULT = 4096;

    localparam int MODE_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int OFFSET_W = 14;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE_REL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MOVE_ABS  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MOVE_END  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
    } gbts_cmd_t;

    typedef struct packed {
        logic at_target;
    } gbts_sts_t;

endpackage

>>> hw/rtl/gbts_ctrl.sv
// ----------------------------------------------------------------------------
// Gap-buffer text store: controller
// Two-state sequencer: takes a word, steps cursor moves byte by byte and
// raises the result strobe when the operation has settled.
// ----------------------------------------------------------------------------
module gbts_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gbts_pkg::MODE_W-1:0]  mode,
    input  gbts_pkg::gbts_sts_t          sts,
    output gbts_pkg::gbts_cmd_t          cmd,
    output logic                         busy,
    output logic                         done
);
    import gbts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic move_reg;
    logic move_next;
    logic is_move;

    assign is_move = (mode == MODE_MOVE_REL) || (mode == MODE_MOVE_ABS) ||
                     (mode == MODE_MOVE_END);

    assign busy     = (state_reg == S_RUN);
    assign cmd.load = start && (state_reg == S_IDLE);
    assign cmd.step = (state_reg == S_RUN) && move_reg && !sts.at_target;
    assign done     = (state_reg == S_RUN) && (!move_reg || sts.at_target);

    always_comb
    begin
        state_next = state_reg;
        move_next  = move_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    move_next  = is_move;
                end
            end
            S_RUN:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            move_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            move_reg  <= move_next;
        end
    end

endmodule

>>> hw/rtl/gbts_datapath.sv
// ----------------------------------------------------------------------------
// Gap-buffer text store: datapath
// Text memory, gap pointers and result registers. All but cursor moves
// complete on load; a cursor move copies one byte across the gap per step
// through a read-then-write pipeline.
// ----------------------------------------------------------------------------
module gbts_datapath
#(
    parameter int BUFFER_DEPTH = gbts_pkg::DEPTH_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  gbts_pkg::gbts_cmd_t            cmd,
    output gbts_pkg::gbts_sts_t            sts,
    input  logic [gbts_pkg::MODE_W-1:0]    mode,
    input  logic [gbts_pkg::CHAR_W-1:0]    char_in,
    input  logic signed [gbts_pkg::OFFSET_W-1:0] offset,
    input  logic [gbts_pkg::COUNT_W-1:0]   delete_before,
    input  logic [gbts_pkg::COUNT_W-1:0]   delete_after,
    output logic [gbts_pkg::COUNT_W-1:0]   cursor_pos,
    output logic [gbts_pkg::COUNT_W-1:0]   text_length,
    output logic [gbts_pkg::CHAR_W-1:0]    char_out,
    output logic [gbts_pkg::STATUS_W-1:0]  status
);
    import gbts_pkg::*;

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int PTR_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(BUFFER_DEPTH);

    logic [CHAR_W-1:0] text_store [BUFFER_DEPTH];

    logic [PTR_W-1:0]    gap_begin_reg, gap_begin_next;
    logic [PTR_W-1:0]    gap_finish_reg, gap_finish_next;
    logic [PTR_W-1:0]    target_reg, target_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                read_ok_reg, read_ok_next;
    logic                wr_pending_reg, wr_pending_next;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;
    logic [CHAR_W-1:0]   rd_data_reg;

    logic [PTR_W-1:0]    len;
    logic [31:0]         len32, gb32, gf32, after32, db32, da32, idx32;
    logic signed [31:0]  off_s, gb_s, len_s, tgt_s;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_wa, mem_ra;
    logic [CHAR_W-1:0]   mem_wd;
    logic [31:0]         word32;

    assign len     = gap_begin_reg + (DEPTH_P - gap_finish_reg);
    assign len32   = 32'(len);
    assign gb32    = 32'(gap_begin_reg);
    assign gf32    = 32'(gap_finish_reg);
    assign after32 = 32'(DEPTH_P - gap_finish_reg);
    assign db32    = 32'(delete_before);
    assign da32    = 32'(delete_after);
    assign off_s   = 32'(offset);
    assign gb_s    = signed'(gb32);
    assign len_s   = signed'(len32);
    assign idx32   = (off_s >= gb_s) ? (32'(off_s) + gf32 - gb32) : 32'(off_s);

    assign sts.at_target = (gap_begin_reg == target_reg);

    always_comb
    begin
        gap_begin_next  = gap_begin_reg;
        gap_finish_next = gap_finish_reg;
        target_next     = target_reg;
        status_next     = status_reg;
        read_ok_next    = read_ok_reg;
        wr_addr_next    = wr_addr_reg;
        wr_pending_next = 1'b0;
        mem_we          = wr_pending_reg;
        mem_wa          = wr_addr_reg;
        mem_wd          = rd_data_reg;
        mem_re          = 1'b0;
        mem_ra          = idx32[AW-1:0];
        tgt_s           = gb_s;
        word32          = 32'd0;

        if (cmd.load)
        begin
            status_next  = ST_OK;
            read_ok_next = 1'b0;
            target_next  = gap_begin_reg;
            unique case (mode)
                MODE_INSERT:
                begin
                    if (gap_begin_reg >= gap_finish_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        mem_wa         = gap_begin_reg[AW-1:0];
                        mem_wd         = char_in;
                        gap_begin_next = gap_begin_reg + PTR_W'(1);
                    end
                end
                MODE_MOVE_REL, MODE_MOVE_ABS, MODE_MOVE_END:
                begin
                    if (mode == MODE_MOVE_REL)
                    begin
                        tgt_s = gb_s + off_s;
                    end
                    else if (mode == MODE_MOVE_ABS)
                    begin
                        tgt_s = off_s;
                    end
                    else
                    begin
                        tgt_s = len_s - off_s;
                    end
                    if (tgt_s < 0)
                    begin
                        tgt_s       = 32'sd0;
                        status_next = ST_RANGE;
                    end
                    else if (tgt_s > len_s)
                    begin
                        tgt_s       = len_s;
                        status_next = ST_RANGE;
                    end
                    word32      = 32'(tgt_s);
                    target_next = word32[PTR_W-1:0];
                end
                MODE_DELETE:
                begin
                    word32 = (db32 > gb32) ? gb32 : db32;
                    gap_begin_next = gap_begin_reg - word32[PTR_W-1:0];
                    word32 = (da32 > after32) ? after32 : da32;
                    gap_finish_next = gap_finish_reg + word32[PTR_W-1:0];
                    if ((db32 > gb32) || (da32 > after32))
                    begin
                        status_next = ST_RANGE;
                    end
                    target_next = gap_begin_next;
                end
                MODE_CLEAR:
                begin
                    gap_begin_next  = '0;
                    gap_finish_next = DEPTH_P;
                    target_next     = '0;
                end
                MODE_READ:
                begin
                    if ((off_s < 0) || (off_s >= len_s))
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        read_ok_next = 1'b1;
                        mem_re       = 1'b1;
                        mem_ra       = idx32[AW-1:0];
                    end
                end
                default:
                begin
                    status_next = ST_RANGE;
                end
            endcase
        end
        else if (cmd.step)
        begin
            wr_pending_next = 1'b1;
            mem_re          = 1'b1;
            if (gap_begin_reg > target_reg)
            begin
                gap_begin_next  = gap_begin_reg - PTR_W'(1);
                gap_finish_next = gap_finish_reg - PTR_W'(1);
                mem_ra          = gap_begin_next[AW-1:0];
                wr_addr_next    = gap_finish_next[AW-1:0];
            end
            else
            begin
                gap_begin_next  = gap_begin_reg + PTR_W'(1);
                gap_finish_next = gap_finish_reg + PTR_W'(1);
                mem_ra          = gap_finish_reg[AW-1:0];
                wr_addr_next    = gap_begin_reg[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_store[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= text_store[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_begin_reg  <= '0;
            gap_finish_reg <= DEPTH_P;
            target_reg     <= '0;
            status_reg     <= ST_OK;
            read_ok_reg    <= 1'b0;
            wr_pending_reg <= 1'b0;
            wr_addr_reg    <= '0;
        end
        else
        begin
            gap_begin_reg  <= gap_begin_next;
            gap_finish_reg <= gap_finish_next;
            target_reg     <= target_next;
            status_reg     <= status_next;
            read_ok_reg    <= read_ok_next;
            wr_pending_reg <= wr_pending_next;
            wr_addr_reg    <= wr_addr_next;
        end
    end

    logic [31:0] cur32;
    assign cur32       = 32'(gap_begin_reg);
    assign cursor_pos  = cur32[COUNT_W-1:0];
    assign text_length = len32[COUNT_W-1:0];
    assign char_out    = read_ok_reg ? rd_data_reg : '0;
    assign status      = status_reg;

endmodule

>>> hw/rtl/gap_buffer_text_store.sv
// ----------------------------------------------------------------------------
// Gap-buffer text store: top level
// Byte text store split by a gap at the cursor; insert, move, delete, clear
// and read operations, one result word per command word.
//
//   Channel   Handshake         Payload
//   command   start / busy      mode, char_in, offset, delete_before,
//                               delete_after
//   result    done (strobe)     cursor_pos, text_length, char_out, status
//
// A new command word is accepted only after the result of the last one.
// Cursor moves also copy the bytes between cursor and target across the gap;
// the single write port of the text memory copies one byte per cycle.
// Reset leaves the text empty with the cursor at zero; the memory is not
// cleared. Results show for one cycle only and the receiver cannot stall.
// ----------------------------------------------------------------------------
module gap_buffer_text_store
#(
    parameter int BUFFER_DEPTH = gbts_pkg::DEPTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [gbts_pkg::MODE_W-1:0]          mode,
    input  logic [gbts_pkg::CHAR_W-1:0]          char_in,
    input  logic signed [gbts_pkg::OFFSET_W-1:0] offset,
    input  logic [gbts_pkg::COUNT_W-1:0]         delete_before,
    input  logic [gbts_pkg::COUNT_W-1:0]         delete_after,
    output logic                                 done,
    output logic [gbts_pkg::COUNT_W-1:0]         cursor_pos,
    output logic [gbts_pkg::COUNT_W-1:0]         text_length,
    output logic [gbts_pkg::CHAR_W-1:0]          char_out,
    output logic [gbts_pkg::STATUS_W-1:0]        status
);
    import gbts_pkg::*;

    gbts_cmd_t cmd;
    gbts_sts_t sts;

    gbts_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    gbts_datapath
    #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (mode),
        .char_in       (char_in),
        .offset        (offset),
        .delete_before (delete_before),
        .delete_after  (delete_after),
        .cursor_pos    (cursor_pos),
        .text_length   (text_length),
        .char_out      (char_out),
        .status        (status)
    );

endmodule

>>> hw/rtl/gbts_checker.sv
// ----------------------------------------------------------------------------
// Gap-buffer text store: port checker
// Watch the command and result ports for sequencing and result sanity.
// ----------------------------------------------------------------------------
module gbts_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic [gbts_pkg::COUNT_W-1:0]         cursor_pos,
    input logic [gbts_pkg::COUNT_W-1:0]         text_length,
    input logic [gbts_pkg::CHAR_W-1:0]          char_out,
    input logic [gbts_pkg::STATUS_W-1:0]        status
);
    import gbts_pkg::*;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without a word in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status <= ST_RANGE) && (cursor_pos <= text_length)))
        else $error("undefined status code or cursor beyond the text");

    a_fail_char: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (char_out == '0))
        else $error("character returned on a failed operation");

endmodule

bind gap_buffer_text_store gbts_checker u_gbts_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .cursor_pos  (cursor_pos),
    .text_length (text_length),
    .char_out    (char_out),
    .status      (status)
);

>>> test/gap_buffer_text_store_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap-buffer text store: result checker
// Watches the command and result channels. Keeps its own copy of the text
// store and the gap, works out the result word of every accepted command
// word and compares each result word, field by field, with the oldest one
// still awaited. Hands the mismatch count and the number of awaited words
// to the testbench top.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_chk
#(
    parameter int DEPTH = gbts_pkg::DEPTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [gbts_pkg::MODE_W-1:0]          mode,
    input  logic [gbts_pkg::CHAR_W-1:0]          char_in,
    input  logic signed [gbts_pkg::OFFSET_W-1:0] offset,
    input  logic [gbts_pkg::COUNT_W-1:0]         delete_before,
    input  logic [gbts_pkg::COUNT_W-1:0]         delete_after,
    input  logic                                 done,
    input  logic [gbts_pkg::COUNT_W-1:0]         cursor_pos,
    input  logic [gbts_pkg::COUNT_W-1:0]         text_length,
    input  logic [gbts_pkg::CHAR_W-1:0]          char_out,
    input  logic [gbts_pkg::STATUS_W-1:0]        status,
    output int                                   mismatches,
    output int                                   outstanding
);

    import gbts_pkg::*;

    typedef struct {
        logic [COUNT_W-1:0]  cursor;
        logic [COUNT_W-1:0]  length;
        logic [CHAR_W-1:0]   ch;
        logic [STATUS_W-1:0] st;
    } edit_outcome_t;

    edit_outcome_t     awaited_words[$];
    logic [CHAR_W-1:0] text_mem [DEPTH];
    int                gap_lo;
    int                gap_hi;

    function automatic int text_len();
        return gap_lo + DEPTH - gap_hi;
    endfunction

    function automatic logic [STATUS_W-1:0] shift_gap(int target);
        logic [STATUS_W-1:0] st;
        int                  len;
        st  = ST_OK;
        len = text_len();
        if (target < 0)
        begin
            target = 0;
            st     = ST_RANGE;
        end
        else if (target > len)
        begin
            target = len;
            st     = ST_RANGE;
        end
        while (gap_lo > target)
        begin
            gap_lo--;
            gap_hi--;
            text_mem[gap_hi] = text_mem[gap_lo];
        end
        while (gap_lo < target && gap_hi < DEPTH)
        begin
            text_mem[gap_lo] = text_mem[gap_hi];
            gap_lo++;
            gap_hi++;
        end
        return st;
    endfunction

    task automatic apply_edit(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                              input int off, input int db, input int da);
        edit_outcome_t w;
        int            idx;
        int            after;
        w.ch = '0;
        w.st = ST_OK;
        case (m)
            MODE_INSERT:
            begin
                if (gap_lo >= gap_hi)
                    w.st = ST_FULL;
                else
                begin
                    text_mem[gap_lo] = c;
                    gap_lo++;
                end
            end
            MODE_MOVE_REL: w.st = shift_gap(gap_lo + off);
            MODE_MOVE_ABS: w.st = shift_gap(off);
            MODE_MOVE_END: w.st = shift_gap(text_len() - off);
            MODE_DELETE:
            begin
                after = DEPTH - gap_hi;
                if (db > gap_lo)
                begin
                    db   = gap_lo;
                    w.st = ST_RANGE;
                end
                if (da > after)
                begin
                    da   = after;
                    w.st = ST_RANGE;
                end
                gap_lo -= db;
                gap_hi += da;
            end
            MODE_CLEAR:
            begin
                gap_lo = 0;
                gap_hi = DEPTH;
            end
            MODE_READ:
            begin
                if (off < 0 || off >= text_len())
                    w.st = ST_RANGE;
                else
                begin
                    idx = off;
                    if (idx >= gap_lo)
                        idx += gap_hi - gap_lo;
                    if (idx < DEPTH)
                        w.ch = text_mem[idx];
                end
            end
            default: w.st = ST_RANGE;
        endcase
        w.cursor = COUNT_W'(gap_lo);
        w.length = COUNT_W'(text_len());
        awaited_words.push_back(w);
    endtask

    task automatic compare_field(input string name, input logic [COUNT_W-1:0] want,
                                 input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        edit_outcome_t w;
        if (!rst_n)
        begin
            gap_lo      = 0;
            gap_hi      = DEPTH;
            awaited_words.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (start && !busy)
                apply_edit(mode, char_in, int'(offset), int'(delete_before),
                           int'(delete_after));
            if (done)
            begin
                if (awaited_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with none awaited, expected none, %s %0d %0d %0h %0d",
                             $time, "actual", cursor_pos, text_length, char_out, status);
                end
                else
                begin
                    w = awaited_words.pop_front();
                    compare_field("cursor_pos", w.cursor, cursor_pos);
                    compare_field("text_length", w.length, text_length);
                    compare_field("char_out", COUNT_W'(w.ch), COUNT_W'(char_out));
                    compare_field("status", COUNT_W'(w.st), COUNT_W'(status));
                end
            end
            outstanding = awaited_words.size();
        end
    end

endmodule

>>> test/gap_buffer_text_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap-buffer text store: testbench top
// Drives command words with random idle gaps: a short directed run over the
// field extremes and the clamped and out-of-range cases, then random edit
// sequences kept to short texts. The checker beside the block predicts and
// compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_tb;

    import gbts_pkg::*;

    localparam int                DEPTH      = DEPTH_DEFAULT;
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [MODE_W-1:0]          mode;
    logic [CHAR_W-1:0]          char_in;
    logic signed [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]         delete_before;
    logic [COUNT_W-1:0]         delete_after;
    logic                       done;
    logic [COUNT_W-1:0]         cursor_pos;
    logic [COUNT_W-1:0]         text_length;
    logic [CHAR_W-1:0]          char_out;
    logic [STATUS_W-1:0]        status;

    int fail_count;
    int awaiting_count;
    int seen_len;
    int seen_cur;
    bit calm;
    bit stuck;

    gap_buffer_text_store #(.BUFFER_DEPTH(DEPTH)) uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .char_in       (char_in),
        .offset        (offset),
        .delete_before (delete_before),
        .delete_after  (delete_after),
        .done          (done),
        .cursor_pos    (cursor_pos),
        .text_length   (text_length),
        .char_out      (char_out),
        .status        (status)
    );

    gap_buffer_text_store_chk #(.DEPTH(DEPTH)) chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .char_in       (char_in),
        .offset        (offset),
        .delete_before (delete_before),
        .delete_after  (delete_after),
        .done          (done),
        .cursor_pos    (cursor_pos),
        .text_length   (text_length),
        .char_out      (char_out),
        .status        (status),
        .mismatches    (fail_count),
        .outstanding   (awaiting_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // track the text roughly, to keep random texts short
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            seen_len <= 0;
            seen_cur <= 0;
        end
        else if (done)
        begin
            seen_len <= int'(text_length);
            seen_cur <= int'(cursor_pos);
        end
    end

    function automatic int idle_span();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 60);
    endfunction

    function automatic int aim(int lo, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return lo - 2 + int'($urandom_range(0, hi - lo + 4));
        else if (r < 90)
            return int'($urandom_range(0, 16383)) - 8192;
        case ($urandom_range(0, 3))
            0:       return -8192;
            1:       return 8191;
            2:       return -1;
            default: return hi + 1;
        endcase
    endfunction

    function automatic int span_count(int avail);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 3);
        else if (r < 85)
            return $urandom_range(0, avail + 1);
        else if (r < 93)
            return $urandom_range(0, 8191);
        else
            return 8191;
    endfunction

    task automatic send_word(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                             input int off, input int db, input int da);
        int idle;
        idle = idle_span();
        @(negedge clk);
        if (idle > 0)
        begin
            start = 1'b0;
            repeat (idle) @(negedge clk);
        end
        mode          = m;
        char_in       = c;
        offset        = OFFSET_W'(off);
        delete_before = COUNT_W'(db);
        delete_after  = COUNT_W'(da);
        start         = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic random_word();
        int                r;
        int                wild;
        int                rest;
        logic [CHAR_W-1:0] pick;
        r    = $urandom_range(0, 99);
        wild = int'($urandom_range(0, 16383)) - 8192;
        rest = seen_len - seen_cur;
        pick = CHAR_W'($urandom_range(0, 255));
        if (seen_len > 300)
        begin
            if (r < 10)       r = 0;
            else if (r < 22)  r = 1;
            else if (r < 30)  r = 2;
            else if (r < 38)  r = 3;
            else if (r < 60)  r = 4;
            else if (r < 75)  r = 5;
            else if (r < 97)  r = 6;
            else              r = 7;
        end
        else
        begin
            if (r < 40)       r = 0;
            else if (r < 52)  r = 1;
            else if (r < 60)  r = 2;
            else if (r < 68)  r = 3;
            else if (r < 76)  r = 4;
            else if (r < 78)  r = 5;
            else if (r < 98)  r = 6;
            else              r = 7;
        end
        case (r)
            0: send_word(MODE_INSERT, pick, wild,
                         $urandom_range(0, 8191), $urandom_range(0, 8191));
            1: send_word(MODE_MOVE_REL, pick, aim(-seen_cur, rest),
                         $urandom_range(0, 8191), $urandom_range(0, 8191));
            2: send_word(MODE_MOVE_ABS, pick, aim(0, seen_len),
                         $urandom_range(0, 8191), $urandom_range(0, 8191));
            3: send_word(MODE_MOVE_END, pick, aim(0, seen_len),
                         $urandom_range(0, 8191), $urandom_range(0, 8191));
            4: send_word(MODE_DELETE, pick, wild,
                         span_count(seen_cur), span_count(rest));
            5: send_word(MODE_CLEAR, pick, wild,
                         $urandom_range(0, 8191), $urandom_range(0, 8191));
            6: send_word(MODE_READ, pick, aim(0, seen_len - 1),
                         $urandom_range(0, 8191), $urandom_range(0, 8191));
            default: send_word(MODE_SPARE, pick, wild,
                               $urandom_range(0, 8191), $urandom_range(0, 8191));
        endcase
    endtask

    initial
    begin : stimulus
        int waited;
        rst_n         = 1'b0;
        start         = 1'b0;
        mode          = MODE_INSERT;
        char_in       = '0;
        offset        = '0;
        delete_before = '0;
        delete_after  = '0;
        calm          = 1'b0;
        stuck         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty store, small text, extremes of every field
        send_word(MODE_READ, 8'h00, 0, 0, 0);
        send_word(MODE_DELETE, 8'h00, 0, 1, 1);
        send_word(MODE_MOVE_REL, 8'h00, -1, 0, 0);
        send_word(MODE_INSERT, 8'h00, 0, 0, 0);
        send_word(MODE_INSERT, 8'hFF, 0, 0, 0);
        send_word(MODE_INSERT, 8'hA5, 0, 0, 0);
        send_word(MODE_INSERT, 8'h5A, 0, 0, 0);
        send_word(MODE_MOVE_ABS, 8'h00, 2, 0, 0);
        send_word(MODE_INSERT, 8'h3C, 0, 0, 0);
        send_word(MODE_MOVE_REL, 8'h00, -8192, 0, 0);
        send_word(MODE_MOVE_REL, 8'h00, 8191, 0, 0);
        send_word(MODE_MOVE_END, 8'h00, 1, 0, 0);
        send_word(MODE_MOVE_END, 8'h00, -8192, 0, 0);
        send_word(MODE_MOVE_END, 8'h00, 8191, 0, 0);
        send_word(MODE_MOVE_ABS, 8'h00, -8192, 0, 0);
        send_word(MODE_MOVE_ABS, 8'h00, 3, 0, 0);
        send_word(MODE_READ, 8'h00, 0, 0, 0);
        send_word(MODE_READ, 8'h00, 4, 0, 0);
        send_word(MODE_READ, 8'h00, 5, 0, 0);
        send_word(MODE_READ, 8'h00, -1, 0, 0);
        send_word(MODE_READ, 8'h00, -8192, 0, 0);
        send_word(MODE_DELETE, 8'h00, 0, 1, 1);
        send_word(MODE_SPARE, 8'hFF, 8191, 8191, 8191);
        send_word(MODE_DELETE, 8'h00, 0, 8191, 8191);
        send_word(MODE_CLEAR, 8'h00, 0, 0, 0);

        // random edit sequences, in stretches that are calm or gappy at random
        for (int n = 0; n < 1425; n++)
        begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            random_word();
        end

        @(negedge clk);
        start  = 1'b0;
        waited = 0;
        while (awaiting_count != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        stuck = (awaiting_count != 0);
        repeat (20) @(negedge clk);

        if (fail_count == 0 && !stuck)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/gbts_pkg.sv
hw/rtl/gbts_ctrl.sv
hw/rtl/gbts_datapath.sv
hw/rtl/gap_buffer_text_store.sv
hw/rtl/gbts_checker.sv
test/gap_buffer_text_store_chk.sv
test/gap_buffer_text_store_tb.sv
